// File: src/spca_pkg.sv
// ============================================================================
// spca_pkg
// Shared constants and request/result types for the path cost aggregation unit.
// ============================================================================
package spca_pkg;

  localparam int COST_BITS  = 24;
  localparam int DISP_SLOTS = 64;
  localparam int DISP_W     = 6;
  localparam int CNT_W      = 7;
  localparam int PEN_W      = 16;
  localparam int SUM_W      = COST_BITS + 2;
  localparam int ADDR_W     = DISP_W + 1;
  localparam int RAM_DEPTH  = 2 * DISP_SLOTS;
  localparam int CFG_IDX_W  = 2;

  localparam int WQ_DEPTH  = 4;
  localparam int WQ_PTR_W  = 2;
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_PTR_W  = 2;

  localparam logic [COST_BITS-1:0] COST_MAX = '1;
  localparam logic [SUM_W-1:0]     SUM_INF  = '1;
  localparam logic [CNT_W-1:0]     DISP_LIM = CNT_W'(DISP_SLOTS);

  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_PEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_PEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_CNT  = 2'd2;

  localparam logic [PEN_W-1:0] SMALL_PEN_RST = 16'd5;
  localparam logic [PEN_W-1:0] LARGE_PEN_RST = 16'd90;
  localparam logic [CNT_W-1:0] DISP_CNT_RST  = 7'd41;

  typedef struct packed {
    logic [COST_BITS-1:0] match_cost;
    logic [DISP_W-1:0]    disparity_index;
    logic                 path_start;
  } in_item_t;

  typedef struct packed {
    logic [COST_BITS-1:0] path_cost;
    logic                 clipped;
    logic                 pixel_done;
  } result_t;

  typedef struct packed {
    logic [PEN_W-1:0] small_pen;
    logic [PEN_W-1:0] large_pen;
    logic [CNT_W-1:0] disp_cnt;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [COST_BITS-1:0] cost;
    logic [SUM_W-1:0]     cost_p2;
    logic [DISP_W-1:0]    disp;
    logic                 first;
    logic                 done;
    logic                 has_right;
    logic                 use_prev;
    logic                 bank;
  } work_t;

endpackage

// File: src/spca_ram.sv
// ============================================================================
// spca_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
module spca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

// File: src/spca_front.sv
// ============================================================================
// spca_front
// Accepts requests, drops out-of-range disparities, tags each request with
// pixel-end, neighbor and vector bank information.
// ============================================================================
module spca_front (
  input  logic                clk,
  input  logic                rst_n,
  input  spca_pkg::cfg_t      cfg,
  input  logic                in_push,
  input  spca_pkg::in_item_t  in_data,
  output logic                in_full,
  input  logic                q_full,
  output logic                q_push,
  output spca_pkg::work_t     q_item
);

  logic                         bank_r;
  logic                         have_prev_r;
  logic [spca_pkg::CNT_W-1:0]   n;
  logic [spca_pkg::CNT_W-1:0]   d_ext;
  logic                         in_range;

  function automatic logic [spca_pkg::CNT_W-1:0] clamp_count(
    input logic [spca_pkg::CNT_W-1:0] cnt
  );
    logic [spca_pkg::CNT_W-1:0] res;
    res = cnt;
    if (cnt == '0) begin
      res = spca_pkg::CNT_W'(1);
    end else if (cnt > spca_pkg::DISP_LIM) begin
      res = spca_pkg::DISP_LIM;
    end
    return res;
  endfunction

  always_comb begin
    n        = clamp_count(cfg.disp_cnt);
    d_ext    = {1'b0, in_data.disparity_index};
    in_range = d_ext < n;
    q_push   = in_push && !q_full && in_range;

    q_item.cost      = in_data.match_cost;
    q_item.cost_p2   = spca_pkg::SUM_W'(in_data.match_cost) + spca_pkg::SUM_W'(cfg.large_pen);
    q_item.disp      = in_data.disparity_index;
    q_item.first     = in_data.disparity_index == '0;
    q_item.done      = d_ext == (n - spca_pkg::CNT_W'(1));
    q_item.has_right = (d_ext + spca_pkg::CNT_W'(1)) < n;
    q_item.use_prev  = !in_data.path_start && have_prev_r;
    q_item.bank      = bank_r;
  end

  assign in_full = q_full;

  // bank_r: half of the vector RAM written by the current pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      have_prev_r <= 1'b0;
    end else if (q_push && q_item.done) begin
      bank_r      <= ~bank_r;
      have_prev_r <= 1'b1;
    end
  end

endmodule

// File: src/spca_queue.sv
// ============================================================================
// spca_queue
// Short request queue between front and back.
// ============================================================================
module spca_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  spca_pkg::work_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output spca_pkg::work_t head
);

  spca_pkg::work_t                entry_r [spca_pkg::WQ_DEPTH];
  logic [spca_pkg::WQ_PTR_W-1:0]  wr_ptr_r;
  logic [spca_pkg::WQ_PTR_W-1:0]  rd_ptr_r;
  logic [spca_pkg::WQ_PTR_W:0]    cnt_r;

  assign full  = cnt_r == (spca_pkg::WQ_PTR_W+1)'(spca_pkg::WQ_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + spca_pkg::WQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + spca_pkg::WQ_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (spca_pkg::WQ_PTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (spca_pkg::WQ_PTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: src/spca_back.sv
// ============================================================================
// spca_back
// Aggregation pipeline: vector read, neighbor candidates, minimum, final sum
// with large penalty and saturation, vector write, result queue.
// ============================================================================
module spca_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [spca_pkg::PEN_W-1:0]    small_pen,
  input  logic                          q_empty,
  input  spca_pkg::work_t               q_item,
  output logic                          q_pop,
  input  logic                          out_pop,
  output logic                          out_empty,
  output spca_pkg::result_t             out_data
);

  localparam int CW = spca_pkg::COST_BITS;
  localparam int SW = spca_pkg::SUM_W;
  localparam int AW = spca_pkg::ADDR_W;

  logic                  en;
  logic                  stall;
  logic                  take;
  logic [AW-1:0]         ra;
  logic [AW-1:0]         rb;
  logic [AW-1:0]         b_wa;
  logic [AW-1:0]         c_wa;
  logic [AW-1:0]         d_wa;
  logic [AW-1:0]         b_ra;
  logic [AW-1:0]         b_rb;

  spca_pkg::work_t       b_item_r;
  spca_pkg::work_t       c_item_r;
  spca_pkg::work_t       d_item_r;
  logic                  b_vld_r;
  logic                  c_vld_r;
  logic                  d_vld_r;

  logic [CW-1:0]         rd_a;
  logic [CW-1:0]         rd_b;
  logic [CW-1:0]         a_fix;
  logic [CW-1:0]         b_fix;
  logic [CW-1:0]         pm1_r;

  logic [SW-1:0]         cand0;
  logic [SW-1:0]         candl;
  logic [SW-1:0]         candr;
  logic [SW-1:0]         c0_r;
  logic [SW-1:0]         cl_r;
  logic [SW-1:0]         cr_r;
  logic [SW-1:0]         best_nxt;
  logic [SW-1:0]         best_r;

  logic [SW-1:0]         sum1;
  logic [SW-1:0]         sum2;
  logic [SW-1:0]         raw;
  logic                  clip;
  logic [CW-1:0]         sum_sat;
  logic [CW-1:0]         run_sel;
  logic [CW-1:0]         run;
  logic [CW-1:0]         run_r;
  logic [CW-1:0]         prev_min_r;

  logic                  fwd_vld_r;
  logic [AW-1:0]         fwd_addr_r;
  logic [CW-1:0]         fwd_data_r;

  logic                  we;

  spca_pkg::result_t                oq_r [spca_pkg::OQ_DEPTH];
  logic [spca_pkg::OQ_PTR_W-1:0]    oq_wr_r;
  logic [spca_pkg::OQ_PTR_W-1:0]    oq_rd_r;
  logic [spca_pkg::OQ_PTR_W:0]      oq_cnt_r;
  logic                             oq_full;
  logic                             oq_push;
  logic                             oq_pop;
  spca_pkg::result_t                res;

  function automatic logic [SW-1:0] min_s(input logic [SW-1:0] x, input logic [SW-1:0] y);
    return (x < y) ? x : y;
  endfunction

  // ---- issue: read previous vector at d and d+1, hold on pending writes in stages b and c ----
  assign ra   = {~q_item.bank, q_item.disp};
  assign rb   = {~q_item.bank, q_item.disp + spca_pkg::DISP_W'(1)};
  assign b_wa = {b_item_r.bank, b_item_r.disp};
  assign c_wa = {c_item_r.bank, c_item_r.disp};
  assign d_wa = {d_item_r.bank, d_item_r.disp};

  assign oq_full = oq_cnt_r == (spca_pkg::OQ_PTR_W+1)'(spca_pkg::OQ_DEPTH);
  assign en      = !(d_vld_r && oq_full);

  always_comb begin
    stall = ((b_vld_r && ra == b_wa) || (c_vld_r && ra == c_wa)) ||
            (q_item.has_right && ((b_vld_r && rb == b_wa) || (c_vld_r && rb == c_wa)));
    take  = en && !q_empty && !stall;
  end

  assign q_pop = take;
  assign we    = en && d_vld_r;

  spca_ram #(
    .WIDTH (CW),
    .DEPTH (spca_pkg::RAM_DEPTH)
  ) u_vec_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (d_wa),
    .wdata   (sum_sat),
    .re      (en),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // ---- candidates: bypass the write that coincided with the read ----
  always_comb begin
    b_ra  = {~b_item_r.bank, b_item_r.disp};
    b_rb  = {~b_item_r.bank, b_item_r.disp + spca_pkg::DISP_W'(1)};
    a_fix = (fwd_vld_r && fwd_addr_r == b_ra) ? fwd_data_r : rd_a;
    b_fix = (fwd_vld_r && fwd_addr_r == b_rb) ? fwd_data_r : rd_b;
    cand0 = SW'(a_fix);
    candl = b_item_r.first ? spca_pkg::SUM_INF : SW'(pm1_r) + SW'(small_pen);
    candr = b_item_r.has_right ? SW'(b_fix) + SW'(small_pen) : spca_pkg::SUM_INF;
  end

  assign best_nxt = min_s(min_s(c0_r, cl_r), cr_r);

  // ---- final: large penalty, saturation, running minimum ----
  always_comb begin
    sum1    = SW'(d_item_r.cost) + best_r;
    sum2    = d_item_r.cost_p2 + SW'(prev_min_r);
    raw     = d_item_r.use_prev ? min_s(sum1, sum2) : SW'(d_item_r.cost);
    clip    = raw[SW-1:CW] != '0;
    sum_sat = clip ? spca_pkg::COST_MAX : raw[CW-1:0];
    run_sel = d_item_r.first ? spca_pkg::COST_MAX : run_r;
    run     = (sum_sat < run_sel) ? sum_sat : run_sel;
    res.path_cost  = sum_sat;
    res.clipped    = clip;
    res.pixel_done = d_item_r.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r    <= 1'b0;
      c_vld_r    <= 1'b0;
      d_vld_r    <= 1'b0;
      fwd_vld_r  <= 1'b0;
      run_r      <= spca_pkg::COST_MAX;
      prev_min_r <= '0;
    end else if (en) begin
      b_vld_r <= take;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      if (d_vld_r) begin
        fwd_vld_r <= 1'b1;
        if (d_item_r.done) begin
          prev_min_r <= run;
          run_r      <= spca_pkg::COST_MAX;
        end else begin
          run_r <= run;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_item_r <= q_item;
      c_item_r <= b_item_r;
      d_item_r <= c_item_r;
      c0_r     <= cand0;
      cl_r     <= candl;
      cr_r     <= candr;
      best_r   <= best_nxt;
      if (b_vld_r) begin
        pm1_r <= a_fix;
      end
      if (d_vld_r) begin
        fwd_addr_r <= d_wa;
        fwd_data_r <= sum_sat;
      end
    end
  end

  // ---- result queue ----
  assign oq_push   = we;
  assign oq_pop    = out_pop && !out_empty;
  assign out_empty = oq_cnt_r == '0;
  assign out_data  = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + spca_pkg::OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + spca_pkg::OQ_PTR_W'(1);
      end
      case ({oq_push, oq_pop})
        2'b10:   oq_cnt_r <= oq_cnt_r + (spca_pkg::OQ_PTR_W+1)'(1);
        2'b01:   oq_cnt_r <= oq_cnt_r - (spca_pkg::OQ_PTR_W+1)'(1);
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

endmodule

// File: src/stereo_path_cost_aggregation_unit.sv
// ============================================================================
// stereo_path_cost_aggregation_unit
// Path cost aggregation along one scan path for semi-global stereo matching.
// ============================================================================
//  channel | ports                          | request moves when
//  --------+--------------------------------+----------------------------
//  input   | in_push, in_full, in_data      | in_push && !in_full
//  result  | out_pop, out_empty, out_data   | out_pop && !out_empty
//  config  | cfg_wr_en, cfg_index, cfg_wdata| cfg_wr_en
//
//  One request per cycle unless the back pipeline stalls; each result is
//  written to the result queue from stage d, after stages b and c.
//  With fewer than four disparity levels, the first levels of a pixel wait
//  until the previous pixel's vector entries are in the RAM.
//  Synchronous active-low reset; no clearing pass, vector RAM is not reset.
//  A full result queue freezes the back pipeline; the request queue absorbs
//  up to four requests meanwhile.
// ============================================================================
module stereo_path_cost_aggregation_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [spca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spca_pkg::PEN_W-1:0]        cfg_wdata,
  input  logic                              in_push,
  input  spca_pkg::in_item_t                in_data,
  output logic                              in_full,
  input  logic                              out_pop,
  output logic                              out_empty,
  output spca_pkg::result_t                 out_data
);

  spca_pkg::cfg_t   cfg_r;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  spca_pkg::work_t  q_in;
  spca_pkg::work_t  q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.small_pen <= spca_pkg::SMALL_PEN_RST;
      cfg_r.large_pen <= spca_pkg::LARGE_PEN_RST;
      cfg_r.disp_cnt  <= spca_pkg::DISP_CNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        spca_pkg::CFG_SMALL_PEN: cfg_r.small_pen <= cfg_wdata;
        spca_pkg::CFG_LARGE_PEN: cfg_r.large_pen <= cfg_wdata;
        spca_pkg::CFG_DISP_CNT:  cfg_r.disp_cnt  <= cfg_wdata[spca_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  spca_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_in)
  );

  spca_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  spca_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .small_pen (cfg_r.small_pen),
    .q_empty   (q_empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

// File: src/spca_checker.sv
// ============================================================================
// spca_checker
// Port-level checks for the path cost aggregation unit, bound to the top.
// ============================================================================
module spca_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [spca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spca_pkg::PEN_W-1:0]        cfg_wdata,
  input  logic                              in_push,
  input  spca_pkg::in_item_t                in_data,
  input  logic                              in_full,
  input  logic                              out_pop,
  input  logic                              out_empty,
  input  spca_pkg::result_t                 out_data
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed or vanished");

  a_clip_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.clipped |-> out_data.path_cost == spca_pkg::COST_MAX)
    else $error("clipped result below cost maximum");

  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    !in_full && !in_push |=> !in_full)
    else $error("input side filled without a request");

endmodule

bind stereo_path_cost_aggregation_unit spca_checker u_spca_checker (.*);
